FILE: src/battery_thermal_charge_control_core_assert.svh
// assertion helpers shared by the charge control modules
`ifndef BATTERY_THERMAL_CHARGE_CONTROL_CORE_ASSERT_SVH
`define BATTERY_THERMAL_CHARGE_CONTROL_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BTCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BTCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/btcc_pkg.sv
package btcc_pkg;

    // field widths
    localparam int TEMP_W      = 8;
    localparam int VOLT_W      = 23;
    localparam int CUR_W       = 13;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 23;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_VOLTAGE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REDUCED_CUR    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_CUR    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_EN      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_THERMAL_EN     = 3'd4;

    // configuration reset values
    localparam logic [VOLT_W-1:0] STOP_VOLTAGE_RST = 23'd4000000;
    localparam logic [CUR_W-1:0]  REDUCED_CUR_RST  = 13'd450;
    localparam logic [CUR_W-1:0]  DEFAULT_CUR_RST  = 13'd1000;

    // temperature band upper limits, degrees C
    localparam logic signed [TEMP_W-1:0] TEMP_FREEZE_MAX = -8'sd11;
    localparam logic signed [TEMP_W-1:0] TEMP_COLD_MAX   = -8'sd5;
    localparam logic signed [TEMP_W-1:0] TEMP_MILD_MAX   = 8'sd42;
    localparam logic signed [TEMP_W-1:0] TEMP_WARM1_MAX  = 8'sd45;
    localparam logic signed [TEMP_W-1:0] TEMP_WARM2_MAX  = 8'sd51;
    localparam logic signed [TEMP_W-1:0] TEMP_HOT_MAX    = 8'sd54;

    // repeat filter window
    localparam logic signed [TEMP_W-1:0] TEMP_FILTER_LO = 8'sd40;
    localparam logic signed [TEMP_W-1:0] TEMP_FILTER_HI = 8'sd50;
    localparam logic signed [TEMP_W:0]   TEMP_DIFF_LO   = -9'sd1;
    localparam logic signed [TEMP_W:0]   TEMP_DIFF_HI   = 9'sd2;
    localparam logic signed [TEMP_W-1:0] TEMP_HELD_RST  = 8'sd25;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_REDUCED = 2'd1,
        MODE_STOPPED = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CHG_NONE      = 3'd0,
        CHG_NORM_STOP = 3'd1,
        CHG_NORM_RED  = 3'd2,
        CHG_RED_NORM  = 3'd3,
        CHG_RED_STOP  = 3'd4,
        CHG_STOP_NORM = 3'd5,
        CHG_STOP_RED  = 3'd6
    } t_change;

    typedef enum logic [1:0] {
        HEALTH_GOOD     = 2'd0,
        HEALTH_OVERHEAT = 2'd1,
        HEALTH_COLD     = 2'd2
    } t_health;

    typedef enum logic [2:0] {
        BAND_FREEZE   = 3'd0,
        BAND_COLD     = 3'd1,
        BAND_MILD     = 3'd2,
        BAND_WARM1    = 3'd3,
        BAND_WARM2    = 3'd4,
        BAND_HOT      = 3'd5,
        BAND_OVERHEAT = 3'd6
    } t_band;

    // charge state machine result for one sample
    typedef struct packed {
        t_mode   mode;
        t_change code;
        logic    plug_in;
        logic    ui_charging;
    } t_fsm_res;

endpackage

FILE: src/btcc_temp_filter.sv
module btcc_temp_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_filter_enable,
    input  logic signed [btcc_pkg::TEMP_W-1:0]  i_temp,
    output btcc_pkg::t_band                     o_band,
    output btcc_pkg::t_health                   o_health
);
    import btcc_pkg::*;

    logic signed [TEMP_W-1:0] r_held_temp;
    logic signed [TEMP_W-1:0] n_held_temp;
    logic signed [TEMP_W:0]   w_diff;
    logic                     w_in_window;
    logic signed [TEMP_W-1:0] w_temp;

    // with the filter enabled, a sample inside the window just keeps the
    // held value and anything else replaces it
    assign w_diff = {i_temp[TEMP_W-1], i_temp} - {r_held_temp[TEMP_W-1], r_held_temp};
    assign w_in_window = (i_temp >= TEMP_FILTER_LO) && (i_temp <= TEMP_FILTER_HI)
                         && (w_diff >= TEMP_DIFF_LO) && (w_diff <= TEMP_DIFF_HI);
    assign w_temp      = (i_filter_enable && w_in_window) ? r_held_temp : i_temp;
    assign n_held_temp = i_filter_enable ? w_temp : r_held_temp;

    // held temperature
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_temp <= TEMP_HELD_RST;
        end else if (i_en) begin
            r_held_temp <= n_held_temp;
        end
    end

    // band sort
    always_comb begin
        if (w_temp <= TEMP_FREEZE_MAX) begin
            o_band = BAND_FREEZE;
        end else if (w_temp <= TEMP_COLD_MAX) begin
            o_band = BAND_COLD;
        end else if (w_temp <= TEMP_MILD_MAX) begin
            o_band = BAND_MILD;
        end else if (w_temp <= TEMP_WARM1_MAX) begin
            o_band = BAND_WARM1;
        end else if (w_temp <= TEMP_WARM2_MAX) begin
            o_band = BAND_WARM2;
        end else if (w_temp <= TEMP_HOT_MAX) begin
            o_band = BAND_HOT;
        end else begin
            o_band = BAND_OVERHEAT;
        end
    end

    // health code from the extreme bands
    always_comb begin
        case (o_band)
            BAND_OVERHEAT: o_health = HEALTH_OVERHEAT;
            BAND_FREEZE:   o_health = HEALTH_COLD;
            default:       o_health = HEALTH_GOOD;
        endcase
    end

endmodule

FILE: src/btcc_fsm.sv
`include "battery_thermal_charge_control_core_assert.svh"

module btcc_fsm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_charger_present,
    input  btcc_pkg::t_band                    i_band,
    input  logic [btcc_pkg::VOLT_W-1:0]        i_voltage,
    input  logic [btcc_pkg::VOLT_W-1:0]        i_stop_voltage,
    output btcc_pkg::t_fsm_res                 o_res
);
    import btcc_pkg::*;

    t_mode   r_mode;
    t_mode   n_mode;
    logic    r_charger_seen;
    logic    r_ui;
    logic    n_ui;
    t_change w_code;
    t_mode   w_mode_eff;
    logic    w_plug;
    logic    w_extreme;
    logic    w_volt_above;
    logic    w_volt_below;

    // plug-in edge restarts from normal
    assign w_plug       = i_charger_present && !r_charger_seen;
    assign w_mode_eff   = w_plug ? MODE_NORMAL : r_mode;
    assign w_extreme    = (i_band == BAND_FREEZE) || (i_band == BAND_OVERHEAT);
    assign w_volt_above = i_voltage > i_stop_voltage;
    assign w_volt_below = i_voltage < i_stop_voltage;

    // next state
    always_comb begin
        n_mode = w_mode_eff;
        case (w_mode_eff)
            MODE_NORMAL: begin
                if (w_extreme) begin
                    n_mode = MODE_STOPPED;
                end else if (i_band >= BAND_WARM2 || i_band <= BAND_COLD) begin
                    n_mode = w_volt_above ? MODE_STOPPED : MODE_REDUCED;
                end
            end
            MODE_REDUCED: begin
                if (w_extreme) begin
                    n_mode = MODE_STOPPED;
                end else if (i_band == BAND_MILD) begin
                    n_mode = MODE_NORMAL;
                end else if (w_volt_above) begin
                    n_mode = MODE_STOPPED;
                end
            end
            MODE_STOPPED: begin
                if (w_extreme) begin
                    n_mode = MODE_STOPPED;
                end else if (i_band == BAND_MILD) begin
                    n_mode = MODE_NORMAL;
                end else if ((i_band == BAND_WARM1 || i_band == BAND_WARM2) && w_volt_below) begin
                    n_mode = MODE_REDUCED;
                end
            end
            default: n_mode = w_mode_eff;
        endcase
    end

    // transition code and ui flag
    always_comb begin
        w_code = CHG_NONE;
        n_ui   = r_ui;
        case (w_mode_eff)
            MODE_NORMAL: begin
                if (w_extreme) begin
                    w_code = CHG_NORM_STOP;
                    n_ui   = 1'b0;
                end else if (i_band >= BAND_WARM2 || i_band <= BAND_COLD) begin
                    w_code = w_volt_above ? CHG_NORM_STOP : CHG_NORM_RED;
                    n_ui   = 1'b1;
                end
            end
            MODE_REDUCED: begin
                if (w_extreme) begin
                    w_code = CHG_RED_STOP;
                    n_ui   = 1'b0;
                end else if (i_band == BAND_MILD) begin
                    w_code = CHG_RED_NORM;
                    n_ui   = 1'b1;
                end else if (w_volt_above) begin
                    w_code = CHG_RED_STOP;
                    n_ui   = 1'b1;
                end
            end
            MODE_STOPPED: begin
                if (w_extreme) begin
                    n_ui   = 1'b0;
                end else if (i_band == BAND_MILD) begin
                    w_code = CHG_STOP_NORM;
                    n_ui   = 1'b1;
                end else if (i_band == BAND_WARM1 || i_band == BAND_WARM2) begin
                    if (w_volt_below) begin
                        w_code = CHG_STOP_RED;
                    end
                    n_ui   = 1'b1;
                end
            end
            default: begin
                w_code = CHG_NONE;
                n_ui   = r_ui;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NORMAL;
            r_charger_seen <= 1'b0;
            r_ui           <= 1'b0;
        end else if (i_en) begin
            r_mode         <= n_mode;
            r_charger_seen <= i_charger_present;
            r_ui           <= n_ui;
        end
    end

    assign o_res.mode        = n_mode;
    assign o_res.code        = w_code;
    assign o_res.plug_in     = w_plug;
    assign o_res.ui_charging = n_ui;

    // checks
    `BTCC_ASSERT_NXT(a_mode_needs_code, i_clk, i_rst_n, i_en && (w_code == CHG_NONE) && !w_plug, r_mode == $past(r_mode), "mode changed without a transition code")
    `BTCC_ASSERT_NXT(a_extreme_stops, i_clk, i_rst_n, i_en && w_extreme, (r_mode == MODE_STOPPED) && !r_ui, "extreme band did not stop charging")
    `BTCC_ASSERT_NXT(a_charger_tracked, i_clk, i_rst_n, i_en, r_charger_seen == $past(i_charger_present), "charger level not recorded")

endmodule

FILE: src/btcc_current.sv
module btcc_current (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_thermal_enable,
    input  btcc_pkg::t_mode                 i_mode,
    input  logic [btcc_pkg::CUR_W-1:0]      i_thermal_limit,
    input  logic [btcc_pkg::CUR_W-1:0]      i_max_current,
    input  logic [btcc_pkg::CUR_W-1:0]      i_reduced_current,
    input  logic [btcc_pkg::CUR_W-1:0]      i_default_current,
    output logic [btcc_pkg::CUR_W-1:0]      o_current,
    output logic                            o_changed
);
    import btcc_pkg::*;

    logic [CUR_W-1:0] r_last_current;

    // drive current by mode, with thermal limit when enabled
    always_comb begin
        if (i_thermal_enable) begin
            case (i_mode)
                MODE_NORMAL: begin
                    o_current = (i_thermal_limit <= i_max_current) ? i_thermal_limit
                                                                   : i_max_current;
                end
                MODE_REDUCED: begin
                    o_current = (i_thermal_limit <= i_reduced_current) ? i_thermal_limit
                                                                       : i_reduced_current;
                end
                default: o_current = i_default_current;
            endcase
        end else begin
            o_current = (i_mode == MODE_REDUCED) ? i_reduced_current : i_default_current;
        end
    end

    assign o_changed = i_thermal_enable && (o_current != r_last_current);

    // last applied current, tracked only under thermal control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_current <= '0;
        end else if (i_en && o_changed) begin
            r_last_current <= o_current;
        end
    end

endmodule

FILE: src/battery_thermal_charge_control_core.sv
// Battery thermal charge control: takes one battery sample per transaction and returns one
// result per sample. A sample is accepted every clock cycle when results are taken; a sample
// is first captured in the input register and is written into the result register when the
// result slot frees, and its result is then offered from the result register.
// The temperature filter, band sort, charge state machine and drive current selection all
// settle between those two registers, so the state left by one sample is in place for the
// next one. A stalled output holds the result register and, once the input register is also
// full, deasserts s_axis_tready. Configuration registers are written through the plain write
// port and take effect for the samples that follow.
`include "battery_thermal_charge_control_core_assert.svh"

module battery_thermal_charge_control_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [btcc_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [btcc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // sample stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // charger_present, temp_celsius, voltage_uv, thermal_limit_ma, max_current_ma, zero pad
    input  logic [btcc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // charge_state, change_code, update_req, charge_disable, drive_current_ma, health,
    // ui_charging, zero pad
    output logic [btcc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import btcc_pkg::*;

    // configuration registers
    logic [VOLT_W-1:0] r_stop_voltage;
    logic [CUR_W-1:0]  r_reduced_current;
    logic [CUR_W-1:0]  r_default_current;
    logic              r_filter_enable;
    logic              r_thermal_enable;

    // input register
    logic                     r_in_valid;
    logic                     r_in_present;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic [VOLT_W-1:0]        r_in_voltage;
    logic [CUR_W-1:0]         r_in_thermal_limit;
    logic [CUR_W-1:0]         r_in_max_current;

    // result register
    logic             r_out_valid;
    t_mode            r_out_state;
    t_change          r_out_code;
    logic             r_out_force;
    logic             r_out_disable;
    logic [CUR_W-1:0] r_out_current;
    t_health          r_out_health;
    logic             r_out_ui;

    logic             w_advance;
    t_band            w_band;
    t_health          w_health;
    t_fsm_res         w_fsm;
    logic [CUR_W-1:0] w_current;
    logic             w_cur_changed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_voltage    <= STOP_VOLTAGE_RST;
            r_reduced_current <= REDUCED_CUR_RST;
            r_default_current <= DEFAULT_CUR_RST;
            r_filter_enable   <= 1'b0;
            r_thermal_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STOP_VOLTAGE: r_stop_voltage    <= i_cfg_data[VOLT_W-1:0];
                CFG_REDUCED_CUR:  r_reduced_current <= i_cfg_data[CUR_W-1:0];
                CFG_DEFAULT_CUR:  r_default_current <= i_cfg_data[CUR_W-1:0];
                CFG_FILTER_EN:    r_filter_enable   <= i_cfg_data[0];
                CFG_THERMAL_EN:   r_thermal_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: the sample in the input register moves on when the result slot frees
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_present       <= s_axis_tdata[0];
            r_in_temp          <= $signed(s_axis_tdata[8:1]);
            r_in_voltage       <= s_axis_tdata[31:9];
            r_in_thermal_limit <= s_axis_tdata[44:32];
            r_in_max_current   <= s_axis_tdata[57:45];
        end
    end

    // temperature filter and band sort
    btcc_temp_filter u_filter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_advance),
        .i_filter_enable (r_filter_enable),
        .i_temp          (r_in_temp),
        .o_band          (w_band),
        .o_health        (w_health)
    );

    // charge state machine
    btcc_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_advance),
        .i_charger_present (r_in_present),
        .i_band            (w_band),
        .i_voltage         (r_in_voltage),
        .i_stop_voltage    (r_stop_voltage),
        .o_res             (w_fsm)
    );

    // drive current selection
    btcc_current u_current (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_advance),
        .i_thermal_enable  (r_thermal_enable),
        .i_mode            (w_fsm.mode),
        .i_thermal_limit   (r_in_thermal_limit),
        .i_max_current     (r_in_max_current),
        .i_reduced_current (r_reduced_current),
        .i_default_current (r_default_current),
        .o_current         (w_current),
        .o_changed         (w_cur_changed)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_state   <= w_fsm.mode;
            r_out_code    <= w_fsm.code;
            r_out_force   <= w_fsm.plug_in || w_cur_changed;
            r_out_disable <= (w_fsm.mode == MODE_STOPPED);
            r_out_current <= w_current;
            r_out_health  <= w_health;
            r_out_ui      <= w_fsm.ui_charging;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ui, r_out_health, r_out_current, r_out_disable,
                            r_out_force, r_out_code, r_out_state};

    // checks
    `BTCC_ASSERT_NXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid, "waiting sample lost")
    `BTCC_ASSERT_IMP(a_stop_code_state, i_clk, i_rst_n, r_out_valid && (r_out_code == CHG_NORM_STOP || r_out_code == CHG_RED_STOP), r_out_state == MODE_STOPPED, "stop transition without stopped state")
    `BTCC_ASSERT_IMP(a_bad_health_stops, i_clk, i_rst_n, r_out_valid && (r_out_health != HEALTH_GOOD), r_out_state == MODE_STOPPED && r_out_disable, "extreme band result not stopped")

endmodule
